// ===== hw/rtl/sadm_pkg.sv =====
package sadm_pkg;

	localparam int unsigned MaxChipDimDef = 256;
	localparam int unsigned PixelBitsDef  = 16;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 17;
	localparam int unsigned DimW     = 9;
	localparam int unsigned StepW    = 16;
	localparam int unsigned PosW     = 17;
	localparam int unsigned FracBits = 8;
	localparam int unsigned SumW     = 32;
	localparam int unsigned TallyW   = 17;
	localparam int unsigned PctW     = 7;
	localparam int unsigned MeanW    = 24;
	localparam int unsigned ProdW    = TallyW + PctW;
	localparam int unsigned DivSteps = MeanW;
	localparam int unsigned DivCntW  = $clog2(DivSteps);

	localparam logic [PosW-1:0]   PosOne   = PosW'(1 << FracBits);
	localparam logic [PosW-1:0]   PosMax   = '1;
	localparam logic [DimW-1:0]   IdxMax   = '1;
	localparam logic [TallyW-1:0] TallyMax = '1;
	localparam logic [SumW-1:0]   SumMax   = '1;
	localparam logic [MeanW-1:0]  MeanMax  = '1;
	localparam logic [PctW-1:0]   Percent  = PctW'(100);

	localparam logic [DimW-1:0]   LinesRst   = DimW'(256);
	localparam logic [DimW-1:0]   SamplesRst = DimW'(256);
	localparam logic [StepW-1:0]  StepRst    = StepW'(256);
	localparam logic [TallyW-1:0] ExpectRst  = TallyW'(65536);
	localparam logic [PctW-1:0]   PctRst     = '0;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_CHIP_LINES   = 3'd0,
		CFG_CHIP_SAMPLES = 3'd1,
		CFG_LINE_STEP    = 3'd2,
		CFG_SAMPLE_STEP  = 3'd3,
		CFG_EXPECTED     = 3'd4,
		CFG_MIN_PERCENT  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic pix_en;
		logic div_load;
		logic div_step;
		logic out_load;
	} sadm_cmd_t;

	typedef struct packed {
		logic div_last;
	} sadm_sts_t;

	function automatic logic [PosW-1:0] advance_pos(
		input logic [PosW-1:0]  pos,
		input logic [StepW-1:0] step
	);
		logic [StepW-1:0] s;
		logic [PosW:0]    n;
		s = (step < StepW'(PosOne)) ? StepW'(PosOne) : step;
		n = {1'b0, pos} + (PosW+1)'(s);
		return n[PosW] ? PosMax : n[PosW-1:0];
	endfunction

endpackage

// ===== hw/rtl/sadm_ctrl.sv =====
module sadm_ctrl import sadm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      chip_end,
	input  logic      out_stall,
	input  sadm_sts_t sts,
	output logic      in_stall,
	output logic      out_valid,
	output sadm_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_ACCUM = 3'b001,
		ST_DIV   = 3'b010,
		ST_DONE  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign accept   = in_valid && (state_q == ST_ACCUM);
	assign out_free = !out_valid_q || !out_stall;

	assign cmd.pix_en   = accept;
	assign cmd.div_load = accept && chip_end;
	assign cmd.div_step = (state_q == ST_DIV);
	assign cmd.out_load = (state_q == ST_DONE) && out_free;

	assign in_stall  = (state_q != ST_ACCUM);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (cmd.div_load) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (sts.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_ACCUM;
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hw/rtl/sadm_datapath.sv =====
module sadm_datapath import sadm_pkg::*; #(
	parameter int unsigned MAX_CHIP_DIM = MaxChipDimDef,
	parameter int unsigned PIXEL_BITS   = PixelBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CfgIdxW-1:0]           cfg_index,
	input  logic [CfgDataW-1:0]          cfg_data,
	input  logic signed [PIXEL_BITS-1:0] pattern_pixel,
	input  logic signed [PIXEL_BITS-1:0] search_pixel,
	input  logic                         pattern_invalid,
	input  logic                         search_invalid,
	input  logic                         chip_end,
	input  sadm_cmd_t                    cmd,
	output sadm_sts_t                    sts,
	output logic [MeanW-1:0]             mean_difference,
	output logic                         no_match,
	output logic [TallyW-1:0]            valid_points
);

	localparam int unsigned DimCap = (MAX_CHIP_DIM > 511) ? 511 : MAX_CHIP_DIM;

	logic [DimW-1:0]   lines_q, samples_q;
	logic [StepW-1:0]  lstep_q, sstep_q;
	logic [TallyW-1:0] expect_q;
	logic [PctW-1:0]   pct_q;

	logic [DimW-1:0]   row_q, col_q;
	logic [PosW-1:0]   nrow_q, ncol_q;
	logic [SumW-1:0]   sum_q;
	logic [TallyW-1:0] tally_q;

	logic [DimW-1:0]   row_d, col_d;
	logic [PosW-1:0]   nrow_d, ncol_d;
	logic [SumW-1:0]   sum_d;
	logic [TallyW-1:0] tally_d;

	logic [DimW-1:0]         lines, samples;
	logic                    row_pick, col_pick, pick, bad;
	logic [PIXEL_BITS:0]     diff, diff_neg;
	logic [PIXEL_BITS-1:0]   abs_d;
	logic [SumW:0]           sum_add;

	logic [TallyW-1:0]  rem_q;
	logic [MeanW-1:0]   quo_q;
	logic [TallyW-1:0]  den_q;
	logic               ovf_q;
	logic [DivCntW-1:0] cnt_q;
	logic [TallyW:0]    shifted, rem_sub;
	logic               ge;

	logic [ProdW-1:0]  cnt_pct, need_pct;
	logic              nm;

	logic [MeanW-1:0]  mean_q;
	logic              nm_q;
	logic [TallyW-1:0] vp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lines_q   <= LinesRst;
			samples_q <= SamplesRst;
			lstep_q   <= StepRst;
			sstep_q   <= StepRst;
			expect_q  <= ExpectRst;
			pct_q     <= PctRst;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CHIP_LINES:   lines_q   <= cfg_data[DimW-1:0];
				CFG_CHIP_SAMPLES: samples_q <= cfg_data[DimW-1:0];
				CFG_LINE_STEP:    lstep_q   <= cfg_data[StepW-1:0];
				CFG_SAMPLE_STEP:  sstep_q   <= cfg_data[StepW-1:0];
				CFG_EXPECTED:     expect_q  <= cfg_data[TallyW-1:0];
				CFG_MIN_PERCENT:  pct_q     <= cfg_data[PctW-1:0];
				default: ;
			endcase
		end
	end

	assign lines   = (lines_q > DimW'(DimCap)) ? DimW'(DimCap) : lines_q;
	assign samples = (samples_q > DimW'(DimCap)) ? DimW'(DimCap) : samples_q;

	assign row_pick = (row_q <= lines) && (nrow_q[PosW-1:FracBits] == row_q);
	assign col_pick = (col_q <= samples) && (ncol_q[PosW-1:FracBits] == col_q);
	assign pick     = row_pick && col_pick;
	assign bad      = pattern_invalid || search_invalid;

	assign diff     = $signed({pattern_pixel[PIXEL_BITS-1], pattern_pixel})
	                - $signed({search_pixel[PIXEL_BITS-1], search_pixel});
	assign diff_neg = -diff;
	assign abs_d    = diff[PIXEL_BITS] ? diff_neg[PIXEL_BITS-1:0] : diff[PIXEL_BITS-1:0];
	assign sum_add  = {1'b0, sum_q} + (SumW+1)'(abs_d);

	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		nrow_d  = nrow_q;
		ncol_d  = ncol_q;
		sum_d   = sum_q;
		tally_d = tally_q;
		if (pick) begin
			if (!bad) begin
				sum_d = sum_add[SumW] ? SumMax : sum_add[SumW-1:0];
				if (tally_q != TallyMax) tally_d = tally_q + 1'b1;
			end
			ncol_d = advance_pos(ncol_q, sstep_q);
		end
		if (col_q >= samples) begin
			col_d  = DimW'(1);
			ncol_d = PosOne;
			if (row_pick) nrow_d = advance_pos(nrow_q, lstep_q);
			if (row_q != IdxMax) row_d = row_q + 1'b1;
		end else begin
			col_d = col_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= DimW'(1);
			col_q   <= DimW'(1);
			nrow_q  <= PosOne;
			ncol_q  <= PosOne;
			sum_q   <= '0;
			tally_q <= '0;
		end else if (cmd.pix_en) begin
			if (chip_end) begin
				row_q   <= DimW'(1);
				col_q   <= DimW'(1);
				nrow_q  <= PosOne;
				ncol_q  <= PosOne;
				sum_q   <= '0;
				tally_q <= '0;
			end else begin
				row_q   <= row_d;
				col_q   <= col_d;
				nrow_q  <= nrow_d;
				ncol_q  <= ncol_d;
				sum_q   <= sum_d;
				tally_q <= tally_d;
			end
		end
	end

	assign shifted = {rem_q, quo_q[MeanW-1]};
	assign ge      = (shifted >= {1'b0, den_q});
	assign rem_sub = shifted - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= TallyW'(sum_d[SumW-1:SumW-16]);
			quo_q <= {sum_d[15:0], FracBits'(0)};
			den_q <= tally_d;
			ovf_q <= ({1'b0, sum_d[SumW-1:SumW-16]} >= tally_d);
			cnt_q <= DivCntW'(DivSteps - 1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? rem_sub[TallyW-1:0] : shifted[TallyW-1:0];
			quo_q <= {quo_q[MeanW-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign sts.div_last = cmd.div_step && (cnt_q == '0);

	assign cnt_pct  = ProdW'(den_q) * ProdW'(Percent);
	assign need_pct = ProdW'(pct_q) * ProdW'(expect_q);
	assign nm       = (den_q == '0) || (cnt_pct < need_pct);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			mean_q <= nm ? '0 : (ovf_q ? MeanMax : quo_q);
			nm_q   <= nm;
			vp_q   <= den_q;
		end
	end

	assign mean_difference = mean_q;
	assign no_match        = nm_q;
	assign valid_points    = vp_q;

endmodule

// ===== hw/rtl/sampled_sad_chip_match.sv =====
// Pixel pairs are taken one per cycle while a chip streams in.
// The item carrying chip_end starts a 24-step restoring divider, one quotient bit per cycle;
// input stalls while the divider runs, and the result is then loaded when the output is free and
// held in an output register until taken.
// The next chip's pixels are not taken before the previous chip's result is loaded.
// Reset (asynchronous, active low) clears control and chip state, loads register defaults.
module sampled_sad_chip_match import sadm_pkg::*; #(
	parameter int unsigned MAX_CHIP_DIM = MaxChipDimDef,
	parameter int unsigned PIXEL_BITS   = PixelBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CfgIdxW-1:0]           cfg_index,
	input  logic [CfgDataW-1:0]          cfg_data,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [PIXEL_BITS-1:0] pattern_pixel,
	input  logic signed [PIXEL_BITS-1:0] search_pixel,
	input  logic                         pattern_invalid,
	input  logic                         search_invalid,
	input  logic                         chip_end,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [MeanW-1:0]             mean_difference,
	output logic                         no_match,
	output logic [TallyW-1:0]            valid_points
);

	sadm_cmd_t cmd;
	sadm_sts_t sts;

	assign cfg_ready = 1'b1;

	sadm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.chip_end  (chip_end),
		.out_stall (out_stall),
		.sts       (sts),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	sadm_datapath #(
		.MAX_CHIP_DIM (MAX_CHIP_DIM),
		.PIXEL_BITS   (PIXEL_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.pattern_pixel   (pattern_pixel),
		.search_pixel    (search_pixel),
		.pattern_invalid (pattern_invalid),
		.search_invalid  (search_invalid),
		.chip_end        (chip_end),
		.cmd             (cmd),
		.sts             (sts),
		.mean_difference (mean_difference),
		.no_match        (no_match),
		.valid_points    (valid_points)
	);

endmodule

// ===== hw/rtl/sadm_checker.sv =====
module sadm_checker import sadm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              chip_end,
	input logic              out_valid,
	input logic              out_stall,
	input logic [MeanW-1:0]  mean_difference,
	input logic              no_match,
	input logic [TallyW-1:0] valid_points
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(mean_difference) && $stable(valid_points)
			&& $stable(no_match))
		else $error("stalled result changed");

	a_nomatch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && no_match |-> mean_difference == '0)
		else $error("mean nonzero on no match");

	a_match_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !no_match |-> valid_points != '0)
		else $error("match reported with zero valid points");

	a_end_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && chip_end |=> in_stall)
		else $error("input taken while divider busy");

endmodule

bind sampled_sad_chip_match sadm_checker u_sadm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.chip_end        (chip_end),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.mean_difference (mean_difference),
	.no_match        (no_match),
	.valid_points    (valid_points)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sadm_pkg::*;

	localparam int unsigned MaxDim     = 256;
	localparam int unsigned OneQ8      = 256;
	localparam int unsigned RandItems  = 200;
	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned CalmStart  = 2000;
	localparam int unsigned CalmEnd    = 3500;
	localparam int unsigned MaxReports = 10;
	localparam int unsigned SettleCyc  = 40;

	typedef struct packed {
		logic signed [15:0] pat;
		logic signed [15:0] srch;
		logic               pat_bad;
		logic               srch_bad;
		logic               last;
	} pixel_item_t;

	typedef struct packed {
		logic [MeanW-1:0]  mean;
		logic              nm;
		logic [TallyW-1:0] count;
	} match_res_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	cfg_idx_t            cfg_index = CFG_CHIP_LINES;
	logic [CfgDataW-1:0] cfg_data  = '0;

	logic               in_valid        = 1'b0;
	logic               in_stall;
	logic signed [15:0] pattern_pixel   = '0;
	logic signed [15:0] search_pixel    = '0;
	logic               pattern_invalid = 1'b0;
	logic               search_invalid  = 1'b0;
	logic               chip_end        = 1'b0;

	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [MeanW-1:0]  mean_difference;
	logic              no_match;
	logic [TallyW-1:0] valid_points;

	pixel_item_t pixel_queue[$];
	match_res_t  expected_results[$];
	int unsigned cycles    = 0;
	int unsigned err_count = 0;

	logic [DimW-1:0]   lines_reg   = LinesRst;
	logic [DimW-1:0]   samples_reg = SamplesRst;
	logic [StepW-1:0]  lstep_reg   = StepRst;
	logic [StepW-1:0]  sstep_reg   = StepRst;
	logic [TallyW-1:0] expect_reg  = ExpectRst;
	logic [PctW-1:0]   pct_reg     = PctRst;

	int unsigned       row_at;
	int unsigned       col_at;
	int unsigned       row_next;
	int unsigned       col_next;
	longint unsigned   sad_sum;
	int unsigned       hits;

	sampled_sad_chip_match i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pattern_pixel   (pattern_pixel),
		.search_pixel    (search_pixel),
		.pattern_invalid (pattern_invalid),
		.search_invalid  (search_invalid),
		.chip_end        (chip_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.mean_difference (mean_difference),
		.no_match        (no_match),
		.valid_points    (valid_points)
	);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	function automatic bit take_break();
		return (cycles < CalmStart || cycles >= CalmEnd) && ($urandom_range(99) < 20);
	endfunction

	function automatic int unsigned clamp_dim(int unsigned d);
		return (d > MaxDim) ? MaxDim : d;
	endfunction

	function automatic int unsigned next_pos(int unsigned pos, int unsigned step);
		int unsigned s;
		int unsigned n;
		s = (step < OneQ8) ? OneQ8 : step;
		n = pos + s;
		return (n > int'(PosMax)) ? int'(PosMax) : n;
	endfunction

	task automatic clear_chip_state();
		row_at   = 1;
		col_at   = 1;
		row_next = OneQ8;
		col_next = OneQ8;
		sad_sum  = 0;
		hits     = 0;
	endtask

	task automatic predict_pixel(pixel_item_t px);
		int unsigned     n_lines;
		int unsigned     n_samples;
		bit              row_hit;
		bit              col_hit;
		int              diff;
		longint unsigned lhs;
		longint unsigned rhs;
		longint unsigned quo;
		match_res_t      res;
		n_lines   = clamp_dim(lines_reg);
		n_samples = clamp_dim(samples_reg);
		row_hit   = row_at <= n_lines && (row_next >> 8) == row_at;
		col_hit   = col_at <= n_samples && (col_next >> 8) == col_at;
		if (row_hit && col_hit) begin
			if (!px.pat_bad && !px.srch_bad) begin
				diff = int'(px.pat) - int'(px.srch);
				sad_sum += longint'((diff < 0) ? -diff : diff);
				if (sad_sum > SumMax)
					sad_sum = SumMax;
				if (hits < TallyMax)
					hits++;
			end
			col_next = next_pos(col_next, sstep_reg);
		end
		if (col_at >= n_samples) begin
			col_at   = 1;
			col_next = OneQ8;
			if (row_hit)
				row_next = next_pos(row_next, lstep_reg);
			if (row_at < IdxMax)
				row_at++;
		end else begin
			col_at++;
		end
		if (px.last) begin
			lhs    = longint'(hits) * 100;
			rhs    = longint'(pct_reg) * longint'(expect_reg);
			res.nm = (hits == 0) || (lhs < rhs);
			quo    = 0;
			if (!res.nm) begin
				quo = (sad_sum << 8) / hits;
				if (quo > MeanMax)
					quo = MeanMax;
			end
			res.mean  = quo[MeanW-1:0];
			res.count = hits[TallyW-1:0];
			expected_results.push_back(res);
			clear_chip_state();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : pixel_driver
		pixel_item_t nxt;
		if (!arst_n) begin
			in_valid        <= 1'b0;
			pattern_pixel   <= '0;
			search_pixel    <= '0;
			pattern_invalid <= 1'b0;
			search_invalid  <= 1'b0;
			chip_end        <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				predict_pixel(pixel_item_t'{pattern_pixel, search_pixel, pattern_invalid,
					search_invalid, chip_end});
			if (!in_valid || !in_stall) begin
				if (pixel_queue.size() > 0 && !take_break()) begin
					nxt = pixel_queue.pop_front();
					pattern_pixel   <= nxt.pat;
					search_pixel    <= nxt.srch;
					pattern_invalid <= nxt.pat_bad;
					search_invalid  <= nxt.srch_bad;
					chip_end        <= nxt.last;
					in_valid        <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : result_monitor
		match_res_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					err_count++;
					if (err_count <= MaxReports)
						$display("unexpected result: mean %0d no_match %0b count %0d",
							mean_difference, no_match, valid_points);
				end else begin
					want = expected_results.pop_front();
					if (want.mean !== mean_difference || want.nm !== no_match ||
							want.count !== valid_points) begin
						err_count++;
						if (err_count <= MaxReports)
							$display("mismatch: mean %0d/%0d no_match %0b/%0b count %0d/%0d",
								want.mean, mean_difference, want.nm, no_match,
								want.count, valid_points);
					end
				end
			end
			out_stall <= take_break();
		end
	end

	task automatic write_reg(cfg_idx_t idx, int unsigned val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CfgDataW'(val);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CHIP_LINES:   lines_reg   = DimW'(val);
			CFG_CHIP_SAMPLES: samples_reg = DimW'(val);
			CFG_LINE_STEP:    lstep_reg   = StepW'(val);
			CFG_SAMPLE_STEP:  sstep_reg   = StepW'(val);
			CFG_EXPECTED:     expect_reg  = TallyW'(val);
			CFG_MIN_PERCENT:  pct_reg     = PctW'(val);
			default: ;
		endcase
	endtask

	task automatic set_config(int unsigned l, int unsigned s, int unsigned ls,
			int unsigned ss, int unsigned ep, int unsigned pc);
		write_reg(CFG_CHIP_LINES, l);
		write_reg(CFG_CHIP_SAMPLES, s);
		write_reg(CFG_LINE_STEP, ls);
		write_reg(CFG_SAMPLE_STEP, ss);
		write_reg(CFG_EXPECTED, ep);
		write_reg(CFG_MIN_PERCENT, pc);
	endtask

	// hold until every item is taken and every result is back, then let the divider settle
	task automatic drain();
		do @(negedge clk);
		while (pixel_queue.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (SettleCyc) @(posedge clk);
	endtask

	function automatic pixel_item_t make_pixel(int a, int b, bit pb, bit sb, bit last);
		pixel_item_t px;
		px.pat      = 16'(a);
		px.srch     = 16'(b);
		px.pat_bad  = pb;
		px.srch_bad = sb;
		px.last     = last;
		return px;
	endfunction

	function automatic pixel_item_t rand_pixel(bit last);
		pixel_item_t px;
		px.pat = 16'($urandom);
		if ($urandom_range(1))
			px.srch = px.pat + 16'($urandom_range(63)) - 16'sd32;
		else
			px.srch = 16'($urandom);
		px.pat_bad  = ($urandom_range(9) == 0);
		px.srch_bad = ($urandom_range(9) == 0);
		px.last     = last;
		return px;
	endfunction

	task automatic queue_chip(int unsigned n_pix);
		for (int unsigned i = 0; i < n_pix; i++)
			pixel_queue.push_back(rand_pixel(i == n_pix - 1));
	endtask

	function automatic int unsigned pick_dim();
		int unsigned r;
		r = $urandom_range(19);
		if (r < 15)
			return $urandom_range(1, 6);
		if (r < 18)
			return $urandom_range(0, 12);
		return $urandom_range(0, 511);
	endfunction

	function automatic int unsigned pick_step();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 2)
			return OneQ8;
		if (r < 8)
			return $urandom_range(256, 700);
		return $urandom_range(65535);
	endfunction

	function automatic int unsigned count_picks(int unsigned dim, int unsigned step);
		int unsigned d;
		int unsigned n;
		int unsigned pos;
		d   = clamp_dim(dim);
		n   = 0;
		pos = OneQ8;
		while ((pos >> 8) <= d) begin
			n++;
			pos = next_pos(pos, step);
		end
		return n;
	endfunction

	initial begin : stimulus
		int unsigned l;
		int unsigned s;
		int unsigned ls;
		int unsigned ss;
		int unsigned ep;
		int unsigned pc;
		int unsigned r;
		int unsigned full;
		int unsigned len;
		int unsigned n_chips;
		int unsigned rand_sent;
		clear_chip_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pixel extremes, flag combinations, early end, all invalid, rows past the chip
		set_config(2, 3, 256, 256, 6, 0);
		pixel_queue.push_back(make_pixel(32767, -32768, 0, 0, 0));
		pixel_queue.push_back(make_pixel(-32768, 32767, 0, 0, 0));
		pixel_queue.push_back(make_pixel(0, 0, 0, 0, 0));
		pixel_queue.push_back(make_pixel(-1, 1, 1, 0, 0));
		pixel_queue.push_back(make_pixel(5, -5, 0, 1, 0));
		pixel_queue.push_back(make_pixel(100, -100, 1, 1, 1));
		pixel_queue.push_back(make_pixel(-32768, -32768, 0, 0, 1));
		pixel_queue.push_back(make_pixel(1, 2, 1, 0, 0));
		pixel_queue.push_back(make_pixel(3, 4, 0, 1, 1));
		queue_chip(8);
		drain();

		// steps below one, full percent threshold
		set_config(2, 2, 0, 255, 4, 100);
		pixel_queue.push_back(make_pixel(10, 3, 0, 0, 0));
		pixel_queue.push_back(make_pixel(-7, -7, 0, 0, 0));
		pixel_queue.push_back(make_pixel(200, -200, 0, 0, 0));
		pixel_queue.push_back(make_pixel(1, 0, 0, 0, 1));
		pixel_queue.push_back(make_pixel(10, 3, 0, 0, 0));
		pixel_queue.push_back(make_pixel(1, 2, 0, 1, 0));
		pixel_queue.push_back(make_pixel(5, 6, 0, 0, 0));
		pixel_queue.push_back(make_pixel(7, 8, 0, 0, 1));
		drain();

		// zero dimensions
		set_config(0, 3, 256, 256, 1, 0);
		queue_chip(3);
		drain();
		set_config(2, 0, 256, 256, 1, 0);
		queue_chip(3);
		drain();

		// dimensions above the maximum, column position saturation
		set_config(300, 511, 65535, 65535, 2, 50);
		queue_chip(257);
		drain();

		// tallest chip, row position saturation, rows past the chip
		set_config(256, 1, 16'hFFFF, 256, 2, 0);
		queue_chip(260);
		drain();

		rand_sent = 0;
		while (rand_sent < RandItems) begin
			l  = pick_dim();
			s  = pick_dim();
			ls = pick_step();
			ss = pick_step();
			ep = ($urandom_range(9) < 7) ? count_picks(l, ls) * count_picks(s, ss)
				: $urandom_range(131071);
			r  = $urandom_range(9);
			if (r < 5)
				pc = $urandom_range(100);
			else if (r < 7)
				pc = 0;
			else if (r < 9)
				pc = 100;
			else
				pc = $urandom_range(101, 127);
			set_config(l, s, ls, ss, ep, pc);
			full    = clamp_dim(l) * clamp_dim(s);
			n_chips = $urandom_range(3, 8);
			repeat (n_chips) begin
				if (full == 0 || full > 64)
					len = $urandom_range(1, 64);
				else if ($urandom_range(9) < 8)
					len = full;
				else
					len = $urandom_range(1, full + 6);
				queue_chip(len);
				rand_sent += len;
			end
			drain();
		end

		if (err_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin : watchdog
		wait (cycles >= CycleLimit);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sampled_sad_chip_match.f =====
hw/rtl/sadm_pkg.sv
hw/rtl/sadm_ctrl.sv
hw/rtl/sadm_datapath.sv
hw/rtl/sampled_sad_chip_match.sv
hw/rtl/sadm_checker.sv
tb/sv/tb_top.sv
